// File: hw/rtl/fpmr_pkg.sv
// shared types, step codes and neighbor offsets for the fcc pair rate block
`timescale 1ns / 1ps

package fpmr_pkg;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_WRITE_SITE  = 2'd0,
      FUNC_READ_SITE   = 2'd1,
      FUNC_EVAL_PAIR   = 2'd2,
      FUNC_WRITE_TABLE = 2'd3
   } func_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_CLASS,
      ST_FINISH
   } state_type;

   // lattice read sequence step
   typedef logic [4:0] step_type;

   localparam int       NB_COUNT        = 12;
   localparam step_type STEP_SITE       = 5'd0;
   localparam step_type STEP_PARTNER    = 5'd1;
   localparam step_type STEP_SITE_NB    = 5'd2;
   localparam step_type STEP_PARTNER_NB = 5'd14;
   localparam step_type STEP_READ_LAST  = 5'd13;
   localparam step_type STEP_EVAL_LAST  = 5'd25;

   // neighbor offset per axis, two's complement
   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
      logic signed [1:0] dz;
   } nb_off_type;

   localparam logic signed [1:0] OFF_P = 2'sb01;
   localparam logic signed [1:0] OFF_Z = 2'sb00;
   localparam logic signed [1:0] OFF_M = 2'sb11;

   // commands from the controller to the datapath
   typedef struct packed {
      logic     load;
      logic     write;
      logic     issue;
      step_type step;
      logic     lookup;
      logic     load_rsp;
   } fpmr_cmd_type;

   // the twelve fcc neighbor directions
   function automatic nb_off_type nb_offset(input logic [3:0] dir);
      nb_off_type off;
      case (dir)
         4'd0:    off = '{dx: OFF_P, dy: OFF_Z, dz: OFF_P};
         4'd1:    off = '{dx: OFF_Z, dy: OFF_M, dz: OFF_P};
         4'd2:    off = '{dx: OFF_M, dy: OFF_Z, dz: OFF_P};
         4'd3:    off = '{dx: OFF_Z, dy: OFF_P, dz: OFF_P};
         4'd4:    off = '{dx: OFF_P, dy: OFF_P, dz: OFF_Z};
         4'd5:    off = '{dx: OFF_M, dy: OFF_P, dz: OFF_Z};
         4'd6:    off = '{dx: OFF_Z, dy: OFF_P, dz: OFF_M};
         4'd7:    off = '{dx: OFF_P, dy: OFF_Z, dz: OFF_M};
         4'd8:    off = '{dx: OFF_M, dy: OFF_Z, dz: OFF_M};
         4'd9:    off = '{dx: OFF_Z, dy: OFF_M, dz: OFF_M};
         4'd10:   off = '{dx: OFF_P, dy: OFF_M, dz: OFF_Z};
         4'd11:   off = '{dx: OFF_M, dy: OFF_M, dz: OFF_Z};
         default: off = '{dx: OFF_Z, dy: OFF_Z, dz: OFF_Z};
      endcase
      return off;
   endfunction

endpackage

// File: hw/rtl/fpmr_ctrl.sv
// controller state machine: transaction sequencing and lattice read stepping
`timescale 1ns / 1ps

module fpmr_ctrl import fpmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_func,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output fpmr_cmd_type cmd
);

   state_type state_ff, state_in;
   func_type  op_ff, op_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   step_type  step_last;
   logic      rsp_free;

   assign step_last = (op_ff == FUNC_EVAL_PAIR) ? STEP_EVAL_LAST : STEP_READ_LAST;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = func_type'(req_func);
               step_in = STEP_SITE;
               case (func_type'(req_func))
                  FUNC_READ_SITE: state_in = ST_SCAN;
                  FUNC_EVAL_PAIR: state_in = ST_SCAN;
                  default:        state_in = ST_WRITE;
               endcase
            end
         end
         ST_WRITE:  state_in = ST_FINISH;
         ST_SCAN: begin
            if (step_ff == step_last) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_DRAIN:  state_in = ST_CLASS;
         ST_CLASS:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.write    = (state_ff == ST_WRITE);
      cmd.issue    = (state_ff == ST_SCAN);
      cmd.step     = step_ff;
      cmd.lookup   = (state_ff == ST_CLASS);
      cmd.load_rsp = (state_ff == ST_FINISH) && rsp_free;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= FUNC_WRITE_SITE;
         step_ff      <= STEP_SITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // the scan never runs past the last lattice read of an evaluation
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> step_ff <= STEP_EVAL_LAST)
      else $error("scan step beyond evaluation sequence");

   // a site read stops after the site neighbors
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == FUNC_READ_SITE) |-> step_ff <= STEP_READ_LAST)
      else $error("site read scan too long");

   // only reads and evaluations scan the lattice
   a_scan_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (op_ff == FUNC_READ_SITE || op_ff == FUNC_EVAL_PAIR))
      else $error("scan for a write transaction");

   // the drain cycle always follows the last scan step
   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && step_ff == step_last) |=> state_ff == ST_DRAIN)
      else $error("drain did not follow last scan step");

endmodule

// File: hw/rtl/fpmr_dp.sv
// datapath: lattice memory, probability table, neighbor counters, result register
`timescale 1ns / 1ps

module fpmr_dp import fpmr_pkg::*; #(
   parameter int DIM_BITS     = 5,
   parameter int RATE_CLASSES = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  fpmr_cmd_type        cmd,
   input  logic [1:0]          req_func,
   input  logic [DIM_BITS-1:0] req_site_x,
   input  logic [DIM_BITS-1:0] req_site_y,
   input  logic [DIM_BITS-1:0] req_site_z,
   input  logic [DIM_BITS-1:0] req_partner_x,
   input  logic [DIM_BITS-1:0] req_partner_y,
   input  logic [DIM_BITS-1:0] req_partner_z,
   input  logic                req_new_species,
   input  logic [3:0]          req_class_index,
   input  logic [31:0]         req_class_value,
   output logic                rsp_species_out,
   output logic                rsp_eligible,
   output logic [3:0]          rsp_rate_class,
   output logic [31:0]         rsp_probability,
   output logic                rsp_status
);

   localparam int             ADDR_W    = 3 * DIM_BITS;
   localparam int             SITES     = 1 << ADDR_W;
   localparam int             CLS_W     = $clog2(RATE_CLASSES);
   localparam logic [4:0]     CLS_LIMIT = 5'(RATE_CLASSES);
   localparam logic [3:0]     CLS_MAX   = 4'(RATE_CLASSES - 1);

   // latched transaction
   func_type            func_ff;
   logic [DIM_BITS-1:0] sx_ff, sy_ff, sz_ff, px_ff, py_ff, pz_ff;
   logic                nsp_ff;
   logic [3:0]          idx_ff;
   logic [31:0]         val_ff;

   // storage
   logic                lattice [SITES];
   logic [31:0]         prob_tbl [RATE_CLASSES];
   logic                mem_rd_ff;
   logic [31:0]         tbl_rd_ff;

   // read pipeline tag and accumulators
   logic                tag_vld_ff;
   step_type            tag_step_ff;
   logic                tag_excl_ff;
   logic                sp_a_ff, sp_p_ff, any_one_ff;
   logic [3:0]          cnt_a_ff, cnt_p_ff;
   logic [3:0]          cls_ff;

   // read address generation
   logic                on_site;
   logic [3:0]          dir;
   nb_off_type          off;
   logic [DIM_BITS-1:0] bx, by, bz, ox, oy, oz, nx, ny, nz;
   logic [ADDR_W-1:0]   rd_addr;
   logic                excl;

   always_comb begin
      on_site = (cmd.step < STEP_PARTNER_NB);
      dir     = on_site ? 4'(cmd.step - STEP_SITE_NB) : 4'(cmd.step - STEP_PARTNER_NB);
      off     = nb_offset(dir);
      bx      = on_site ? sx_ff : px_ff;
      by      = on_site ? sy_ff : py_ff;
      bz      = on_site ? sz_ff : pz_ff;
      ox      = on_site ? px_ff : sx_ff;
      oy      = on_site ? py_ff : sy_ff;
      oz      = on_site ? pz_ff : sz_ff;
      nx      = bx + DIM_BITS'(off.dx);
      ny      = by + DIM_BITS'(off.dy);
      nz      = bz + DIM_BITS'(off.dz);
      excl    = (nx == ox) && (ny == oy) && (nz == oz);
      if (cmd.step == STEP_SITE) begin
         rd_addr = {sx_ff, sy_ff, sz_ff};
      end else if (cmd.step == STEP_PARTNER) begin
         rd_addr = {px_ff, py_ff, pz_ff};
      end else begin
         rd_addr = {nx, ny, nz};
      end
   end

   // latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         sx_ff   <= req_site_x;
         sy_ff   <= req_site_y;
         sz_ff   <= req_site_z;
         px_ff   <= req_partner_x;
         py_ff   <= req_partner_y;
         pz_ff   <= req_partner_z;
         nsp_ff  <= req_new_species;
         idx_ff  <= req_class_index;
         val_ff  <= req_class_value;
      end
   end

   // lattice memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write && func_ff == FUNC_WRITE_SITE) begin
         lattice[{sx_ff, sy_ff, sz_ff}] <= nsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mem_rd_ff <= lattice[rd_addr];
      end
   end

   // probability table, writes beyond the class count are dropped
   always_ff @(posedge clock) begin
      if (cmd.write && func_ff == FUNC_WRITE_TABLE && {1'b0, idx_ff} < CLS_LIMIT) begin
         prob_tbl[idx_ff[CLS_W-1:0]] <= val_ff;
      end
   end

   // read tag is registered alongside the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= 1'b0;
      end else begin
         tag_vld_ff <= cmd.issue;
      end
      tag_step_ff <= cmd.step;
      tag_excl_ff <= excl;
   end

   // species capture and species-0 neighbor counting
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         cnt_a_ff   <= '0;
         cnt_p_ff   <= '0;
         any_one_ff <= 1'b0;
      end else if (tag_vld_ff) begin
         if (tag_step_ff == STEP_SITE) begin
            sp_a_ff <= mem_rd_ff;
         end else if (tag_step_ff == STEP_PARTNER) begin
            sp_p_ff <= mem_rd_ff;
         end else if (tag_step_ff < STEP_PARTNER_NB) begin
            any_one_ff <= any_one_ff | mem_rd_ff;
            if (!tag_excl_ff && !mem_rd_ff) begin
               cnt_a_ff <= cnt_a_ff + 4'd1;
            end
         end else begin
            if (!tag_excl_ff && !mem_rd_ff) begin
               cnt_p_ff <= cnt_p_ff + 4'd1;
            end
         end
      end
   end

   // clamped count difference and table lookup
   logic [3:0] diff, cls_c;

   always_comb begin
      diff  = cnt_a_ff - cnt_p_ff;
      cls_c = (cnt_a_ff > cnt_p_ff) ? diff : 4'd0;
      if ({1'b0, cls_c} >= CLS_LIMIT) begin
         cls_c = CLS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         cls_ff    <= cls_c;
         tbl_rd_ff <= prob_tbl[cls_c[CLS_W-1:0]];
      end
   end

   // result assembly
   logic        res_species, res_eligible, res_status, pair_bad;
   logic [3:0]  res_class;
   logic [31:0] res_prob;

   always_comb begin
      res_species  = 1'b0;
      res_eligible = 1'b0;
      res_class    = 4'd0;
      res_prob     = 32'd0;
      res_status   = 1'b0;
      pair_bad     = sp_a_ff || !sp_p_ff;
      case (func_ff)
         FUNC_READ_SITE: begin
            res_species  = sp_a_ff;
            res_eligible = !sp_a_ff && any_one_ff;
         end
         FUNC_EVAL_PAIR: begin
            if (pair_bad) begin
               res_status = 1'b1;
            end else begin
               res_class = cls_ff;
               res_prob  = tbl_rd_ff;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_species_out <= res_species;
         rsp_eligible    <= res_eligible;
         rsp_rate_class  <= res_class;
         rsp_probability <= res_prob;
         rsp_status      <= res_status;
      end
   end

   // neighbor counts never exceed the neighbor total
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= 4'(NB_COUNT)) && (cnt_p_ff <= 4'(NB_COUNT)))
      else $error("neighbor count overflow");

   // a registered read always carries a tag of the previous issue
   a_tag_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> tag_vld_ff && tag_step_ff == $past(cmd.step))
      else $error("read tag lost");

   // the looked-up class always lies inside the table
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> cls_ff <= CLS_MAX)
      else $error("rate class beyond table");

endmodule

// File: hw/rtl/fcc_pair_metropolis_rate.sv
// top level: fcc binary-alloy lattice with metropolis exchange rate lookup
`timescale 1ns / 1ps
//
// Usage:
//   req_* is the request channel (valid/ready). req_func selects site write,
//   site read, pair evaluation or probability table write. rsp_* returns one
//   result transaction per request (valid/ready), fields zero where unused.
//   Each request is sequenced to completion before the next is accepted;
//   a pair evaluation is paced by the single read port of the lattice
//   memory, which reads the two sites and their 24 neighbors one per cycle,
//   followed by a drain, a table lookup and a result load.
//   A finished result sits in an output register; a new request is accepted
//   while it waits. When the receiver stalls, the next result waits in its
//   final state and no further request is taken until it moves out.
//   Reset (synchronous, active high) returns the controller to idle and drops
//   any pending result. Lattice and table contents are not cleared: entries
//   must be written before they are read.
//
module fcc_pair_metropolis_rate import fpmr_pkg::*; #(
   parameter int DIM_BITS     = 5,
   parameter int RATE_CLASSES = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [DIM_BITS-1:0] req_site_x,
   input  logic [DIM_BITS-1:0] req_site_y,
   input  logic [DIM_BITS-1:0] req_site_z,
   input  logic [DIM_BITS-1:0] req_partner_x,
   input  logic [DIM_BITS-1:0] req_partner_y,
   input  logic [DIM_BITS-1:0] req_partner_z,
   input  logic                req_new_species,
   input  logic [3:0]          req_class_index,
   input  logic [31:0]         req_class_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_species_out,
   output logic                rsp_eligible,
   output logic [3:0]          rsp_rate_class,
   output logic [31:0]         rsp_probability,
   output logic                rsp_status
);

   fpmr_cmd_type cmd;

   // sequencing
   fpmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // storage and arithmetic
   fpmr_dp #(
      .DIM_BITS     (DIM_BITS),
      .RATE_CLASSES (RATE_CLASSES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_site_x      (req_site_x),
      .req_site_y      (req_site_y),
      .req_site_z      (req_site_z),
      .req_partner_x   (req_partner_x),
      .req_partner_y   (req_partner_y),
      .req_partner_z   (req_partner_z),
      .req_new_species (req_new_species),
      .req_class_index (req_class_index),
      .req_class_value (req_class_value),
      .rsp_species_out (rsp_species_out),
      .rsp_eligible    (rsp_eligible),
      .rsp_rate_class  (rsp_rate_class),
      .rsp_probability (rsp_probability),
      .rsp_status      (rsp_status)
   );

endmodule

// File: bench/fcc_pair_metropolis_rate_checker.sv
// checker for the fcc pair rate block: predicts every response and compares it field by field
`timescale 1ns / 1ps

module fcc_pair_metropolis_rate_checker import fpmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  func_type    req_func,
   input  logic [4:0]  req_site_x,
   input  logic [4:0]  req_site_y,
   input  logic [4:0]  req_site_z,
   input  logic [4:0]  req_partner_x,
   input  logic [4:0]  req_partner_y,
   input  logic [4:0]  req_partner_z,
   input  logic        req_new_species,
   input  logic [3:0]  req_class_index,
   input  logic [31:0] req_class_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_species_out,
   input  logic        rsp_eligible,
   input  logic [3:0]  rsp_rate_class,
   input  logic [31:0] rsp_probability,
   input  logic        rsp_status,
   output int          fail_count,
   output int          open_count
);

   localparam int SITES     = 1 << 15;
   localparam int CLASSES   = 12;
   localparam int NB_DIRS   = 12;

   // fcc neighbor offsets per axis
   localparam int STEP_X [NB_DIRS] = '{1, 0, -1, 0, 1, -1, 0, 1, -1, 0, 1, -1};
   localparam int STEP_Y [NB_DIRS] = '{0, -1, 0, 1, 1, 1, 1, 0, 0, -1, -1, -1};
   localparam int STEP_Z [NB_DIRS] = '{1, 1, 1, 1, 0, 0, -1, -1, -1, -1, 0, 0};

   typedef logic [4:0] coord_type;

   typedef struct packed {
      logic        species;
      logic        eligible;
      logic [3:0]  rate_class;
      logic [31:0] probability;
      logic        status;
   } rate_rsp_type;

   logic         species_map [0:SITES-1];
   logic [31:0]  prob_table  [0:CLASSES-1];
   rate_rsp_type rate_responses_due [$];

   initial fail_count = 0;
   initial open_count = 0;

   function automatic logic [14:0] site_index(input coord_type x, input coord_type y,
                                              input coord_type z);
      return {x, y, z};
   endfunction

   // species-0 neighbors of a site, leaving out one excluded site
   function automatic int zero_neighbors_except(input coord_type x, input coord_type y,
                                                input coord_type z, input coord_type ex,
                                                input coord_type ey, input coord_type ez);
      int        count;
      coord_type nx, ny, nz;
      count = 0;
      for (int d = 0; d < NB_DIRS; d++) begin
         nx = coord_type'(x + STEP_X[d]);
         ny = coord_type'(y + STEP_Y[d]);
         nz = coord_type'(z + STEP_Z[d]);
         if (!(nx == ex && ny == ey && nz == ez) && species_map[site_index(nx, ny, nz)] == 1'b0)
            count++;
      end
      return count;
   endfunction

   function automatic logic any_one_neighbor(input coord_type x, input coord_type y,
                                             input coord_type z);
      logic found;
      found = 1'b0;
      for (int d = 0; d < NB_DIRS; d++) begin
         if (species_map[site_index(coord_type'(x + STEP_X[d]), coord_type'(y + STEP_Y[d]),
                                    coord_type'(z + STEP_Z[d]))] == 1'b1)
            found = 1'b1;
      end
      return found;
   endfunction

   // apply one transaction to the lattice and table copy and work out its response
   task automatic compute_rate_response(output rate_rsp_type r);
      int          ni, nf, cls;
      logic [14:0] a_idx, p_idx;
      r     = '0;
      a_idx = site_index(req_site_x, req_site_y, req_site_z);
      p_idx = site_index(req_partner_x, req_partner_y, req_partner_z);
      case (req_func)
         FUNC_WRITE_SITE: species_map[a_idx] = req_new_species;
         FUNC_READ_SITE: begin
            r.species  = species_map[a_idx];
            r.eligible = !r.species && any_one_neighbor(req_site_x, req_site_y, req_site_z);
         end
         FUNC_EVAL_PAIR: begin
            if (species_map[a_idx] != 1'b0 || species_map[p_idx] != 1'b1) begin
               r.status = 1'b1;
            end else begin
               ni  = zero_neighbors_except(req_site_x, req_site_y, req_site_z,
                                           req_partner_x, req_partner_y, req_partner_z);
               nf  = zero_neighbors_except(req_partner_x, req_partner_y, req_partner_z,
                                           req_site_x, req_site_y, req_site_z);
               cls = (ni > nf) ? ni - nf : 0;
               if (cls >= CLASSES)
                  cls = CLASSES - 1;
               r.rate_class  = 4'(cls);
               r.probability = prob_table[cls];
            end
         end
         FUNC_WRITE_TABLE: begin
            if (req_class_index < CLASSES)
               prob_table[req_class_index] = req_class_value;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   // responses are checked before new transactions are queued
   always @(posedge clock) begin
      rate_rsp_type want, got;
      if (reset) begin
         rate_responses_due.delete();
         open_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_species_out, rsp_eligible, rsp_rate_class, rsp_probability, rsp_status};
            if (rate_responses_due.size() == 0) begin
               report_mismatch("unexpected response", got[31:0], 32'd0);
            end else begin
               want = rate_responses_due.pop_front();
               if (got.species != want.species)
                  report_mismatch("species_out", 32'(got.species), 32'(want.species));
               if (got.eligible != want.eligible)
                  report_mismatch("eligible", 32'(got.eligible), 32'(want.eligible));
               if (got.rate_class != want.rate_class)
                  report_mismatch("rate_class", 32'(got.rate_class), 32'(want.rate_class));
               if (got.probability != want.probability)
                  report_mismatch("probability", got.probability, want.probability);
               if (got.status != want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
            end
         end
         if (req_valid && req_ready) begin
            compute_rate_response(want);
            rate_responses_due = {rate_responses_due, want};
         end
         open_count <= rate_responses_due.size();
      end
   end

endmodule

// File: bench/fcc_pair_metropolis_rate_tb.sv
// testbench top for the fcc pair rate block: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module fcc_pair_metropolis_rate_tb;
   import fpmr_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 400;

   typedef struct packed {
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
   } site_type;

   typedef struct packed {
      func_type    func;
      site_type    site;
      site_type    partner;
      logic        new_species;
      logic [3:0]  class_index;
      logic [31:0] class_value;
   } lattice_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   func_type    req_func = FUNC_WRITE_SITE;
   logic [4:0]  req_site_x = '0;
   logic [4:0]  req_site_y = '0;
   logic [4:0]  req_site_z = '0;
   logic [4:0]  req_partner_x = '0;
   logic [4:0]  req_partner_y = '0;
   logic [4:0]  req_partner_z = '0;
   logic        req_new_species = 1'b0;
   logic [3:0]  req_class_index = '0;
   logic [31:0] req_class_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_species_out;
   logic        rsp_eligible;
   logic [3:0]  rsp_rate_class;
   logic [31:0] rsp_probability;
   logic        rsp_status;

   int          fail_count;
   int          open_count;
   int          sent_items = 0;
   int          idle_cycles = 0;
   logic        quiet = 1'b0;

   always #5 clock = ~clock;

   fcc_pair_metropolis_rate i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_site_x      (req_site_x),
      .req_site_y      (req_site_y),
      .req_site_z      (req_site_z),
      .req_partner_x   (req_partner_x),
      .req_partner_y   (req_partner_y),
      .req_partner_z   (req_partner_z),
      .req_new_species (req_new_species),
      .req_class_index (req_class_index),
      .req_class_value (req_class_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_species_out (rsp_species_out),
      .rsp_eligible    (rsp_eligible),
      .rsp_rate_class  (rsp_rate_class),
      .rsp_probability (rsp_probability),
      .rsp_status      (rsp_status)
   );

   fcc_pair_metropolis_rate_checker i_rate_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_site_x      (req_site_x),
      .req_site_y      (req_site_y),
      .req_site_z      (req_site_z),
      .req_partner_x   (req_partner_x),
      .req_partner_y   (req_partner_y),
      .req_partner_z   (req_partner_z),
      .req_new_species (req_new_species),
      .req_class_index (req_class_index),
      .req_class_value (req_class_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_species_out (rsp_species_out),
      .rsp_eligible    (rsp_eligible),
      .rsp_rate_class  (rsp_rate_class),
      .rsp_probability (rsp_probability),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   // receiver back-pressure, off during the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 13);
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic int ring_dist(input int a, input int c);
      int d;
      d = (a - c) & 31;
      return (d > 16) ? 32 - d : d;
   endfunction

   // initial lattice: an all-zero block around the origin with a lone one at the origin,
   // an all-one block around the center with a lone zero at the center, a second
   // all-one block, random species elsewhere
   function automatic logic fill_species(input int x, input int y, input int z);
      if (ring_dist(x, 0) <= 3 && ring_dist(y, 0) <= 3 && ring_dist(z, 0) <= 3)
         return (x == 0 && y == 0 && z == 0);
      if (ring_dist(x, 16) <= 2 && ring_dist(y, 16) <= 2 && ring_dist(z, 16) <= 2)
         return !(x == 16 && y == 16 && z == 16);
      if (ring_dist(x, 8) <= 2 && ring_dist(y, 24) <= 2 && ring_dist(z, 8) <= 2)
         return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [31:0] random_prob();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'h8000_0000;
         2:       return 32'h7fff_ffff;
         default: return $urandom & 32'h7fff_ffff;
      endcase
   endfunction

   // a small box across the wrap corner, its neighbors and theirs stay in the origin block
   function automatic site_type pick_site();
      site_type s;
      s.x = 5'(31 + $urandom_range(0, 2));
      s.y = 5'(31 + $urandom_range(0, 2));
      s.z = 5'(31 + $urandom_range(0, 2));
      return s;
   endfunction

   function automatic site_type neighbor_of(input site_type s, input int dir);
      nb_off_type off;
      site_type   n;
      off = nb_offset(4'(dir));
      n.x = s.x + {{3{off.dx[1]}}, off.dx};
      n.y = s.y + {{3{off.dy[1]}}, off.dy};
      n.z = s.z + {{3{off.dz[1]}}, off.dz};
      return n;
   endfunction

   // unused fields carry random values
   function automatic lattice_req_type random_req(input func_type f);
      lattice_req_type r;
      r.func        = f;
      r.site        = 15'($urandom);
      r.partner     = 15'($urandom);
      r.new_species = 1'($urandom);
      r.class_index = 4'($urandom);
      r.class_value = $urandom;
      return r;
   endfunction

   // one transaction, with random idle cycles ahead of it
   task automatic send_item(input lattice_req_type item);
      while (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= item.func;
      req_site_x      <= item.site.x;
      req_site_y      <= item.site.y;
      req_site_z      <= item.site.z;
      req_partner_x   <= item.partner.x;
      req_partner_y   <= item.partner.y;
      req_partner_z   <= item.partner.z;
      req_new_species <= item.new_species;
      req_class_index <= item.class_index;
      req_class_value <= item.class_value;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic write_site(input site_type s, input logic species);
      lattice_req_type r;
      r             = random_req(FUNC_WRITE_SITE);
      r.site        = s;
      r.new_species = species;
      send_item(r);
   endtask

   task automatic read_site(input site_type s);
      lattice_req_type r;
      r      = random_req(FUNC_READ_SITE);
      r.site = s;
      send_item(r);
   endtask

   task automatic eval_pair(input site_type s, input site_type p);
      lattice_req_type r;
      r         = random_req(FUNC_EVAL_PAIR);
      r.site    = s;
      r.partner = p;
      send_item(r);
   endtask

   task automatic write_entry(input logic [3:0] idx, input logic [31:0] value);
      lattice_req_type r;
      r             = random_req(FUNC_WRITE_TABLE);
      r.class_index = idx;
      r.class_value = value;
      send_item(r);
   endtask

   // write every site of a cube around a center, wrapping at the edges
   task automatic fill_block(input int cx, input int cy, input int cz, input int r);
      for (int dx = -r; dx <= r; dx++)
         for (int dy = -r; dy <= r; dy++)
            for (int dz = -r; dz <= r; dz++)
               write_site(site_type'{5'(cx + dx), 5'(cy + dy), 5'(cz + dz)},
                          fill_species((cx + dx) & 31, (cy + dy) & 31, (cz + dz) & 31));
   endtask

   // hold the request channel low until every response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   initial begin
      int       random_items;
      int       base_items;
      int       kind;
      site_type a, b;
      bit       drained_early, drained_late;

      drained_early = 0;
      drained_late  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // probability table, extremes first, then indexes past the table
      for (int i = 0; i < 12; i++) begin
         case (i)
            0:       write_entry(4'(i), 32'd0);
            1:       write_entry(4'(i), 32'h8000_0000);
            2:       write_entry(4'(i), 32'h7fff_ffff);
            default: write_entry(4'(i), random_prob());
         endcase
      end
      write_entry(4'd12, 32'h8000_0000);
      write_entry(4'd15, 32'h7fff_ffff);

      // every site that is ever read lies in one of these blocks and is written first
      fill_block(0, 0, 0, 3);
      fill_block(16, 16, 16, 2);
      fill_block(8, 24, 8, 2);

      // reads: isolated zero, surrounded zero, lone one, far corner, species one
      read_site('{5'd16, 5'd16, 5'd16});
      read_site('{5'd2, 5'd2, 5'd2});
      read_site('{5'd0, 5'd0, 5'd0});
      read_site('{5'd31, 5'd31, 5'd31});
      read_site('{5'd17, 5'd16, 5'd16});
      // class beyond the table saturates
      eval_pair('{5'd2, 5'd2, 5'd2}, '{5'd8, 5'd24, 5'd8});
      // negative difference clamps to zero
      eval_pair('{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd0, 5'd0});
      // neighbor partner left out of both counts
      eval_pair('{5'd1, 5'd0, 5'd1}, '{5'd0, 5'd0, 5'd0});
      eval_pair('{5'd16, 5'd16, 5'd16}, '{5'd17, 5'd16, 5'd17});
      // pairs that are not zero to one
      eval_pair('{5'd0, 5'd0, 5'd0}, '{5'd1, 5'd0, 5'd1});
      eval_pair('{5'd2, 5'd2, 5'd2}, '{5'd3, 5'd3, 5'd2});
      eval_pair('{5'd16, 5'd16, 5'd16}, '{5'd16, 5'd16, 5'd16});
      eval_pair('{5'd31, 5'd31, 5'd31}, '{5'd0, 5'd31, 5'd0});
      // clearing the lone one removes eligibility of its neighbor
      write_site('{5'd0, 5'd0, 5'd0}, 1'b0);
      read_site('{5'd1, 5'd0, 5'd1});

      // random part: mostly well-formed exchange evaluations
      base_items   = sent_items;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            write_site(pick_site(), 1'($urandom_range(0, 1)));
         end else if (kind < 35) begin
            read_site(pick_site());
         end else if (kind < 45) begin
            write_entry(4'($urandom_range(0, 15)), random_prob());
         end else begin
            a = pick_site();
            if ($urandom_range(0, 99) < 20)
               b = pick_site();
            else
               b = neighbor_of(a, $urandom_range(0, 11));
            if ($urandom_range(0, 99) < 70) begin
               repeat ($urandom_range(0, 3))
                  write_site(neighbor_of($urandom_range(0, 1) ? a : b, $urandom_range(0, 11)),
                             1'($urandom_range(0, 1)));
               write_site(a, 1'b0);
               write_site(b, 1'b1);
            end
            eval_pair(a, b);
         end
         random_items = sent_items - base_items;
         quiet <= (random_items >= 150 && random_items < 250);
         if (!drained_early && random_items >= 100) begin
            drained_early = 1;
            drain_responses();
         end else if (!drained_late && random_items >= 300) begin
            drained_late = 1;
            drain_responses();
         end
      end

      drain_responses();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/fpmr_pkg.sv
hw/rtl/fpmr_ctrl.sv
hw/rtl/fpmr_dp.sv
hw/rtl/fcc_pair_metropolis_rate.sv
bench/fcc_pair_metropolis_rate_checker.sv
bench/fcc_pair_metropolis_rate_tb.sv
